// ===== rtl/core/dds_rgba8_stream_parser_defines.svh =====
// Assertion macros used by the DDS stream parser core (ddsp_parse_core).
`ifndef DDS_RGBA8_STREAM_PARSER_DEFINES_SVH
`define DDS_RGBA8_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DDSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ddsp_pkg.sv =====
// Types and constants of the DDS RGBA8 stream parser.
`timescale 1ns / 1ps
`default_nettype none
package ddsp_pkg;

  // file format constants
  localparam logic [31:0] DDS_MAGIC    = 32'h2053_4444;
  localparam logic [31:0] FOURCC_DX10  = 32'h3031_5844;
  localparam int          FLAG_FOURCC_BIT = 2;   // 0x4
  localparam int          FLAG_RGB_BIT    = 6;   // 0x40
  localparam logic [31:0] HEADER_SIZE  = 32'd124;
  localparam logic [6:0]  HEADER_LAST  = 7'd123;
  localparam logic [6:0]  DX10_LAST    = 7'd19;
  localparam logic [31:0] DXGI_RGBA8   = 32'd28;
  localparam logic [31:0] DXGI_BGRA8   = 32'd87;
  localparam logic [31:0] BPP_32       = 32'd32;
  localparam logic [31:0] MASK_BYTE0   = 32'h0000_00ff;
  localparam logic [31:0] MASK_BYTE1   = 32'h0000_ff00;
  localparam logic [31:0] MASK_BYTE2   = 32'h00ff_0000;
  localparam logic [31:0] MASK_BYTE3   = 32'hff00_0000;

  // max_pixel_count register
  localparam int           MAXPIX_W   = 41;
  localparam logic [40:0]  MAXPIX_RST = 41'h1 << 30;

  // configuration port
  localparam int          CFG_ADDR_W = 4;
  localparam int          CFG_DATA_W = 64;
  localparam logic        REG_MAX_PIXEL_COUNT = 1'b0;  // register index, paddr[3]

  // record kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_HEADER    = 3'd2;
  localparam logic [2:0] ERR_DX10      = 3'd3;
  localparam logic [2:0] ERR_FORMAT    = 3'd4;
  localparam logic [2:0] ERR_ZERO_SIZE = 3'd5;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd6;
  localparam logic [2:0] ERR_TRUNCATED = 3'd7;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_DX10,
    PH_PIXELS,
    PH_IGNORE
  } ddsp_phase_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  error_code;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        source_was_bgra;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        final_pixel;
  } ddsp_rec_t;

  // up to two records produced by one accepted byte
  typedef struct packed {
    logic [1:0] n;
    ddsp_rec_t  r0;
    ddsp_rec_t  r1;
  } ddsp_push_t;

endpackage
`default_nettype wire

// ===== rtl/core/ddsp_in_if.sv =====
// Byte input channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface ddsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ddsp_out_if.sv =====
// Record output channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface ddsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [2:0]  error_code;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic        source_was_bgra;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        final_pixel;

  modport source (output valid, output record_kind, output error_code, output image_width,
                  output image_height, output source_was_bgra, output red, output green,
                  output blue, output alpha, output final_pixel, input ready);
  modport sink   (input valid, input record_kind, input error_code, input image_width,
                  input image_height, input source_was_bgra, input red, input green,
                  input blue, input alpha, input final_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ddsp_cfg.sv =====
// APB-style configuration register block holding max_pixel_count.
`timescale 1ns / 1ps
`default_nettype none
module ddsp_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ddsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ddsp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [ddsp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic      [ddsp_pkg::MAXPIX_W-1:0]   max_pixel_count
);
  import ddsp_pkg::*;

  logic [MAXPIX_W-1:0] max_r;
  logic                hit;

  assign hit = (paddr[3] == REG_MAX_PIXEL_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAXPIX_RST;
    end else if (psel && penable && pwrite && hit) begin
      max_r <= pwdata[MAXPIX_W-1:0];
    end
  end

  assign pready          = 1'b1;
  assign prdata          = hit ? {{(CFG_DATA_W-MAXPIX_W){1'b0}}, max_r} : '0;
  assign max_pixel_count = max_r;
endmodule
`default_nettype wire

// ===== rtl/core/ddsp_parse_core.sv =====
// Byte-wise DDS header parser and pixel assembler.
`timescale 1ns / 1ps
`default_nettype none
`include "dds_rgba8_stream_parser_defines.svh"
module ddsp_parse_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_acc,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          end_of_file,
  input  wire logic [ddsp_pkg::MAXPIX_W-1:0] max_pixel_count,
  output ddsp_pkg::ddsp_push_t               push
);
  import ddsp_pkg::*;

  // header byte positions of the last byte of each captured word
  localparam logic [6:0] POS_SIZE   = 7'd3;
  localparam logic [6:0] POS_HEIGHT = 7'd11;
  localparam logic [6:0] POS_WIDTH  = 7'd15;
  localparam logic [6:0] POS_FLAGS  = 7'd79;
  localparam logic [6:0] POS_FOURCC = 7'd83;
  localparam logic [6:0] POS_BPP    = 7'd87;
  localparam logic [6:0] POS_MASK0  = 7'd91;
  localparam logic [6:0] POS_MASK1  = 7'd95;
  localparam logic [6:0] POS_MASK2  = 7'd99;
  localparam logic [6:0] POS_MASK3  = 7'd103;
  localparam logic [6:0] POS_WORD0  = 7'd3;

  // control state
  ddsp_phase_t phase_r, phase_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [1:0]  bip_r, bip_nxt;

  // payload state, always rewritten before use
  logic [31:0]         shift_r, shift_nxt;
  logic [31:0]         hsize_r, hsize_nxt;
  logic [31:0]         flags_r, flags_nxt;
  logic [31:0]         fourcc_r, fourcc_nxt;
  logic [31:0]         bpp_r, bpp_nxt;
  logic [31:0]         mask_r [4];
  logic [31:0]         mask_nxt [4];
  logic [31:0]         dxgi_r, dxgi_nxt;
  logic [31:0]         width_r, width_nxt;
  logic [31:0]         height_r, height_nxt;
  logic [63:0]         product_r;
  logic [MAXPIX_W-1:0] remain_r, remain_nxt;
  logic [23:0]         asm_r, asm_nxt;
  logic                swap_r, swap_nxt;

  logic [31:0] word;
  logic        dx10_tag, is_rgb32, fmt_rgba, fmt_bgra, size_zero, too_big;
  logic        do_classify, fin;
  ddsp_push_t  push_c;

  function automatic ddsp_rec_t err_rec(input logic [2:0] code);
    ddsp_rec_t r;
    r            = '0;
    r.record_kind = KIND_ERROR;
    r.error_code  = code;
    return r;
  endfunction

  assign word     = {data_byte, shift_r[31:8]};
  assign dx10_tag = flags_r[FLAG_FOURCC_BIT] && (fourcc_r == FOURCC_DX10);
  assign is_rgb32 = flags_r[FLAG_RGB_BIT] && (bpp_r == BPP_32);
  assign fmt_rgba = dx10_tag ? (dxgi_r == DXGI_RGBA8)
                             : (is_rgb32 && mask_r[0] == MASK_BYTE0 && mask_r[1] == MASK_BYTE1 &&
                                mask_r[2] == MASK_BYTE2 && mask_r[3] == MASK_BYTE3);
  assign fmt_bgra = dx10_tag ? (dxgi_r == DXGI_BGRA8)
                             : (is_rgb32 && mask_r[0] == MASK_BYTE2 && mask_r[1] == MASK_BYTE1 &&
                                mask_r[2] == MASK_BYTE0 && mask_r[3] == MASK_BYTE3);
  assign size_zero = (width_r == '0) || (height_r == '0);
  assign too_big   = product_r > {{(64-MAXPIX_W){1'b0}}, max_pixel_count};
  assign fin       = remain_r <= MAXPIX_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    bip_nxt     = bip_r;
    shift_nxt   = shift_r;
    hsize_nxt   = hsize_r;
    flags_nxt   = flags_r;
    fourcc_nxt  = fourcc_r;
    bpp_nxt     = bpp_r;
    mask_nxt    = mask_r;
    dxgi_nxt    = dxgi_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    remain_nxt  = remain_r;
    asm_nxt     = asm_r;
    swap_nxt    = swap_r;
    do_classify = 1'b0;
    push_c      = '0;

    if (in_acc) begin
      case (phase_r)
        PH_MAGIC: begin
          shift_nxt = word;
          if (pos_r == POS_WORD0) begin
            pos_nxt = '0;
            if (word != DDS_MAGIC) begin
              push_c.n  = 2'd1;
              push_c.r0 = err_rec(ERR_MAGIC);
              phase_nxt = PH_IGNORE;
            end else begin
              phase_nxt = PH_HEADER;
              if (end_of_file) begin
                push_c.n  = 2'd1;
                push_c.r0 = err_rec(ERR_HEADER);
              end
            end
          end else begin
            pos_nxt = pos_r + 7'd1;
            if (end_of_file) begin
              push_c.n  = 2'd1;
              push_c.r0 = err_rec(ERR_MAGIC);
            end
          end
        end
        PH_HEADER: begin
          shift_nxt = word;
          case (pos_r)
            POS_SIZE:   hsize_nxt   = word;
            POS_HEIGHT: height_nxt  = word;
            POS_WIDTH:  width_nxt   = word;
            POS_FLAGS:  flags_nxt   = word;
            POS_FOURCC: fourcc_nxt  = word;
            POS_BPP:    bpp_nxt     = word;
            POS_MASK0:  mask_nxt[0] = word;
            POS_MASK1:  mask_nxt[1] = word;
            POS_MASK2:  mask_nxt[2] = word;
            POS_MASK3:  mask_nxt[3] = word;
            default: ;
          endcase
          if (pos_r == HEADER_LAST) begin
            pos_nxt = '0;
            if (hsize_r != HEADER_SIZE) begin
              push_c.n  = 2'd1;
              push_c.r0 = err_rec(ERR_HEADER);
              phase_nxt = PH_IGNORE;
            end else if (dx10_tag) begin
              phase_nxt = PH_DX10;
              if (end_of_file) begin
                push_c.n  = 2'd1;
                push_c.r0 = err_rec(ERR_DX10);
              end
            end else begin
              do_classify = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + 7'd1;
            if (end_of_file) begin
              push_c.n  = 2'd1;
              push_c.r0 = err_rec(ERR_HEADER);
            end
          end
        end
        PH_DX10: begin
          shift_nxt = word;
          if (pos_r == POS_WORD0) begin
            dxgi_nxt = word;
          end
          if (pos_r == DX10_LAST) begin
            pos_nxt     = '0;
            do_classify = 1'b1;
          end else begin
            pos_nxt = pos_r + 7'd1;
            if (end_of_file) begin
              push_c.n  = 2'd1;
              push_c.r0 = err_rec(ERR_DX10);
            end
          end
        end
        PH_PIXELS: begin
          if (bip_r != 2'd3) begin
            case (bip_r)
              2'd0:    asm_nxt[7:0]   = data_byte;
              2'd1:    asm_nxt[15:8]  = data_byte;
              default: asm_nxt[23:16] = data_byte;
            endcase
            bip_nxt = bip_r + 2'd1;
            if (end_of_file) begin
              push_c.n  = 2'd1;
              push_c.r0 = err_rec(ERR_TRUNCATED);
            end
          end else begin
            push_c.n                  = 2'd1;
            push_c.r0.record_kind     = KIND_PIXEL;
            push_c.r0.error_code      = ERR_NONE;
            push_c.r0.source_was_bgra = swap_r;
            push_c.r0.red             = swap_r ? asm_r[23:16] : asm_r[7:0];
            push_c.r0.green           = asm_r[15:8];
            push_c.r0.blue            = swap_r ? asm_r[7:0] : asm_r[23:16];
            push_c.r0.alpha           = data_byte;
            push_c.r0.final_pixel     = fin;
            if (remain_r != '0) begin
              remain_nxt = remain_r - MAXPIX_W'(1);
            end
            bip_nxt = '0;
            if (fin) begin
              phase_nxt = PH_IGNORE;
            end else if (end_of_file) begin
              push_c.n  = 2'd2;
              push_c.r1 = err_rec(ERR_TRUNCATED);
            end
          end
        end
        default: ;
      endcase

      // format, then zero size, then pixel-count limit
      if (do_classify) begin
        push_c.n = 2'd1;
        if (!(fmt_rgba || fmt_bgra)) begin
          push_c.r0 = err_rec(ERR_FORMAT);
          phase_nxt = PH_IGNORE;
        end else if (size_zero) begin
          push_c.r0 = err_rec(ERR_ZERO_SIZE);
          phase_nxt = PH_IGNORE;
        end else if (too_big) begin
          push_c.r0 = err_rec(ERR_TOO_LARGE);
          phase_nxt = PH_IGNORE;
        end else begin
          swap_nxt                  = !fmt_rgba;
          remain_nxt                = product_r[MAXPIX_W-1:0];
          bip_nxt                   = '0;
          phase_nxt                 = PH_PIXELS;
          push_c.r0.record_kind     = KIND_HEADER;
          push_c.r0.error_code      = ERR_NONE;
          push_c.r0.image_width     = width_r;
          push_c.r0.image_height    = height_r;
          push_c.r0.source_was_bgra = !fmt_rgba;
          if (end_of_file) begin
            push_c.n  = 2'd2;
            push_c.r1 = err_rec(ERR_TRUNCATED);
          end
        end
      end

      // end of file rearms the parser
      if (end_of_file) begin
        phase_nxt = PH_MAGIC;
        pos_nxt   = '0;
        bip_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      pos_r   <= '0;
      bip_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      bip_r   <= bip_nxt;
    end
  end

  // width is captured at header byte 15; the product has settled long before classification
  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    hsize_r   <= hsize_nxt;
    flags_r   <= flags_nxt;
    fourcc_r  <= fourcc_nxt;
    bpp_r     <= bpp_nxt;
    mask_r    <= mask_nxt;
    dxgi_r    <= dxgi_nxt;
    width_r   <= width_nxt;
    height_r  <= height_nxt;
    product_r <= width_r * height_r;
    remain_r  <= remain_nxt;
    asm_r     <= asm_nxt;
    swap_r    <= swap_nxt;
  end

  assign push = push_c;

  `DDSP_ASSERT_NEXT(a_eof_rearms, clk, rst_n, in_acc && end_of_file,
                    phase_r == PH_MAGIC && pos_r == '0 && bip_r == '0,
                    "parser not rearmed after end of file")
  `DDSP_ASSERT_NEXT(a_final_stops, clk, rst_n,
                    push_c.n != 2'd0 && push_c.r0.record_kind == KIND_PIXEL &&
                    push_c.r0.final_pixel,
                    phase_r == PH_IGNORE || phase_r == PH_MAGIC,
                    "parser still active after final pixel")
  `DDSP_ASSERT_IMPL(a_bip_idle, clk, rst_n, phase_r != PH_PIXELS, bip_r == '0,
                    "pixel byte count left over outside pixel phase")
  `DDSP_ASSERT_IMPL(a_second_is_error, clk, rst_n, push_c.n == 2'd2,
                    push_c.r1.record_kind == KIND_ERROR &&
                    push_c.r1.error_code == ERR_TRUNCATED,
                    "second record of a byte is not a truncation error")
endmodule
`default_nettype wire

// ===== rtl/core/ddsp_out_fifo.sv =====
// Record queue between the parser and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module ddsp_out_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ddsp_pkg::ddsp_push_t push,
  output logic                      space_ok,
  ddsp_out_if.source                out_chan
);
  import ddsp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ddsp_rec_t        mem_r [DEPTH];
  logic [PW-1:0]    rd_ptr_r, wr_ptr_r, wr_ptr1, wr_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             pop;
  ddsp_rec_t        head;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign pop       = out_chan.valid && out_chan.ready;
  assign wr_ptr1   = wrap_inc(wr_ptr_r);
  assign count_nxt = count_r + CW'(push.n) - CW'(pop);
  // room for the two records one byte can produce
  assign space_ok  = count_r <= CW'(DEPTH - 2);

  always_comb begin
    case (push.n)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = wrap_inc(wr_ptr1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

  assign head                     = mem_r[rd_ptr_r];
  assign out_chan.valid           = count_r != '0;
  assign out_chan.record_kind     = head.record_kind;
  assign out_chan.error_code      = head.error_code;
  assign out_chan.image_width     = head.image_width;
  assign out_chan.image_height    = head.image_height;
  assign out_chan.source_was_bgra = head.source_was_bgra;
  assign out_chan.red             = head.red;
  assign out_chan.green           = head.green;
  assign out_chan.blue            = head.blue;
  assign out_chan.alpha           = head.alpha;
  assign out_chan.final_pixel     = head.final_pixel;
endmodule
`default_nettype wire

// ===== rtl/core/dds_rgba8_stream_parser.sv =====
// Records are queued in OUT_DEPTH entries, written when the byte causing them is accepted.
// Throughput: one byte per cycle while in_chan.ready is high; at most two records per byte.
// in_chan.ready is high while the record queue holds OUT_DEPTH-2 records or fewer.
// Reset (rst_n low, synchronous): parser rearms to await magic, queue empties,
// max_pixel_count returns to 2^30.
`timescale 1ns / 1ps
`default_nettype none
module dds_rgba8_stream_parser #(
  parameter int OUT_DEPTH = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ddsp_in_if.sink                              in_chan,
  ddsp_out_if.source                           out_chan,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ddsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ddsp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [ddsp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import ddsp_pkg::*;

  logic [MAXPIX_W-1:0] max_pix;
  logic                in_acc;
  logic                space_ok;
  ddsp_push_t          push;

  assign in_chan.ready   = space_ok;
  assign in_acc          = in_chan.valid && space_ok;

  ddsp_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_pixel_count (max_pix)
  );

  ddsp_parse_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_acc          (in_acc),
    .data_byte       (in_chan.data_byte),
    .end_of_file     (in_chan.end_of_file),
    .max_pixel_count (max_pix),
    .push            (push)
  );

  ddsp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_chan (out_chan)
  );
endmodule
`default_nettype wire

// ===== tb/dds_rgba8_stream_parser_tb.sv =====
// Self-checking testbench for the DDS RGBA8/BGRA8 byte-stream parser.
`timescale 1ns / 1ps
module dds_rgba8_stream_parser_tb;
  import ddsp_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT      = 6;
  localparam int MAGIC_LEN     = 4;
  localparam int PAYLOAD_CAP   = 64;
  localparam int PHASE_BYTES   = 100;
  localparam logic [3:0]  ADDR_MAX_PIXELS = 4'h0;
  localparam logic [3:0]  ADDR_UNMAPPED   = 4'h8;
  localparam logic [40:0] MAXPIX_ALL      = '1;

  typedef enum logic [1:0] {PIXFMT_NONE, PIXFMT_RGBA, PIXFMT_BGRA} pixfmt_t;
  typedef enum int {SRC_RGB_MASKS, SRC_BGR_MASKS, SRC_DX10_RGBA, SRC_DX10_BGRA} src_fmt_t;

  typedef struct {
    logic [31:0] magic;
    logic [31:0] hdr_size;
    logic [31:0] height;
    logic [31:0] width;
    logic [31:0] flags;
    logic [31:0] fourcc;
    logic [31:0] bpp;
    logic [31:0] mask_r;
    logic [31:0] mask_g;
    logic [31:0] mask_b;
    logic [31:0] mask_a;
    logic [31:0] dxgi;
    int          payload_len;
    int          fill;          // -1: random payload bytes
  } dds_spec_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  ddsp_in_if  in_if ();
  ddsp_out_if out_if ();

  dds_rgba8_stream_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // parser shadow state
  ddsp_phase_t mdl_phase;
  logic [7:0]  mdl_pos;
  logic [31:0] mdl_shift;
  logic [31:0] mdl_hdr_size;
  logic [31:0] mdl_flags;
  logic [31:0] mdl_fourcc;
  logic [31:0] mdl_bpp;
  logic [31:0] mdl_mask [4];
  logic [31:0] mdl_dxgi;
  logic [31:0] mdl_width;
  logic [31:0] mdl_height;
  logic [40:0] mdl_left;
  logic [23:0] mdl_asm;
  logic [1:0]  mdl_bip;
  logic        mdl_swap;
  logic [40:0] mdl_max;

  ddsp_rec_t   pending_records [$];
  logic [7:0]  file_q [$];
  int          mismatches;
  int          bytes_sent;
  int          stall_cycles;
  int          hold_left;
  bit          hold_req;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void clear_stream();
    mdl_phase    = PH_MAGIC;
    mdl_pos      = '0;
    mdl_shift    = '0;
    mdl_hdr_size = '0;
    mdl_flags    = '0;
    mdl_fourcc   = '0;
    mdl_bpp      = '0;
    for (int k = 0; k < 4; k++) mdl_mask[k] = '0;
    mdl_dxgi     = '0;
    mdl_width    = '0;
    mdl_height   = '0;
    mdl_left     = '0;
    mdl_asm      = '0;
    mdl_bip      = '0;
    mdl_swap     = 1'b0;
  endfunction

  function automatic void push_rec(logic [1:0] kind, logic [2:0] err, logic [31:0] w,
                                   logic [31:0] h, logic bgra, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b, logic [7:0] a, logic fin);
    ddsp_rec_t rec;
    rec.record_kind     = kind;
    rec.error_code      = err;
    rec.image_width     = w;
    rec.image_height    = h;
    rec.source_was_bgra = bgra;
    rec.red             = r;
    rec.green           = g;
    rec.blue            = b;
    rec.alpha           = a;
    rec.final_pixel     = fin;
    pending_records = {pending_records, rec};
  endfunction

  function automatic void raise_error(logic [2:0] err);
    mdl_phase = PH_IGNORE;
    push_rec(KIND_ERROR, err, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0);
  endfunction

  function automatic logic dx10_tagged();
    return mdl_flags[FLAG_FOURCC_BIT] && (mdl_fourcc == FOURCC_DX10);
  endfunction

  function automatic pixfmt_t detect_format();
    if (dx10_tagged()) begin
      if (mdl_dxgi == DXGI_RGBA8) return PIXFMT_RGBA;
      if (mdl_dxgi == DXGI_BGRA8) return PIXFMT_BGRA;
      return PIXFMT_NONE;
    end
    if (mdl_flags[FLAG_RGB_BIT] && mdl_bpp == BPP_32) begin
      if (mdl_mask[0] == MASK_BYTE0 && mdl_mask[1] == MASK_BYTE1 &&
          mdl_mask[2] == MASK_BYTE2 && mdl_mask[3] == MASK_BYTE3) return PIXFMT_RGBA;
      if (mdl_mask[0] == MASK_BYTE2 && mdl_mask[1] == MASK_BYTE1 &&
          mdl_mask[2] == MASK_BYTE0 && mdl_mask[3] == MASK_BYTE3) return PIXFMT_BGRA;
    end
    return PIXFMT_NONE;
  endfunction

  function automatic void classify_image(logic eof);
    pixfmt_t     fmt;
    logic [63:0] count;
    fmt   = detect_format();
    count = {32'b0, mdl_width} * {32'b0, mdl_height};
    if (fmt == PIXFMT_NONE) raise_error(ERR_FORMAT);
    else if (mdl_width == 0 || mdl_height == 0) raise_error(ERR_ZERO_SIZE);
    else if (count > {23'b0, mdl_max}) raise_error(ERR_TOO_LARGE);
    else begin
      mdl_swap  = (fmt == PIXFMT_BGRA);
      mdl_left  = count[40:0];
      mdl_asm   = '0;
      mdl_bip   = '0;
      mdl_phase = PH_PIXELS;
      push_rec(KIND_HEADER, ERR_NONE, mdl_width, mdl_height, mdl_swap, '0, '0, '0, '0, 1'b0);
      if (eof) raise_error(ERR_TRUNCATED);
    end
  endfunction

  function automatic void capture_word(logic [7:0] ofs, logic [31:0] v);
    case (ofs)
      8'd0:   mdl_hdr_size = v;
      8'd8:   mdl_height   = v;
      8'd12:  mdl_width    = v;
      8'd76:  mdl_flags    = v;
      8'd80:  mdl_fourcc   = v;
      8'd84:  mdl_bpp      = v;
      8'd88:  mdl_mask[0]  = v;
      8'd92:  mdl_mask[1]  = v;
      8'd96:  mdl_mask[2]  = v;
      8'd100: mdl_mask[3]  = v;
      default: ;
    endcase
  endfunction

  function automatic void parse_byte_model(logic [7:0] b, logic eof);
    logic fin;
    case (mdl_phase)
      PH_MAGIC: begin
        mdl_shift = {b, mdl_shift[31:8]};
        mdl_pos++;
        if (mdl_pos >= MAGIC_LEN) begin
          mdl_pos = '0;
          if (mdl_shift != DDS_MAGIC) raise_error(ERR_MAGIC);
          else begin
            mdl_phase = PH_HEADER;
            if (eof) raise_error(ERR_HEADER);
          end
        end else if (eof) raise_error(ERR_MAGIC);
      end
      PH_HEADER: begin
        mdl_shift = {b, mdl_shift[31:8]};
        if (mdl_pos[1:0] == 2'b11) capture_word(mdl_pos - 8'd3, mdl_shift);
        mdl_pos++;
        if (mdl_pos > HEADER_LAST) begin
          mdl_pos = '0;
          if (mdl_hdr_size != HEADER_SIZE) raise_error(ERR_HEADER);
          else if (dx10_tagged()) begin
            mdl_phase = PH_DX10;
            if (eof) raise_error(ERR_DX10);
          end else classify_image(eof);
        end else if (eof) raise_error(ERR_HEADER);
      end
      PH_DX10: begin
        mdl_shift = {b, mdl_shift[31:8]};
        if (mdl_pos == 8'd3) mdl_dxgi = mdl_shift;
        mdl_pos++;
        if (mdl_pos > DX10_LAST) begin
          mdl_pos = '0;
          classify_image(eof);
        end else if (eof) raise_error(ERR_DX10);
      end
      PH_PIXELS: begin
        if (mdl_bip < 2'd3) begin
          mdl_asm = mdl_asm | ({16'b0, b} << (8 * mdl_bip));
          mdl_bip++;
          if (eof) raise_error(ERR_TRUNCATED);
        end else begin
          fin = (mdl_left <= 1);
          if (mdl_swap)
            push_rec(KIND_PIXEL, ERR_NONE, '0, '0, 1'b1, mdl_asm[23:16], mdl_asm[15:8],
                     mdl_asm[7:0], b, fin);
          else
            push_rec(KIND_PIXEL, ERR_NONE, '0, '0, 1'b0, mdl_asm[7:0], mdl_asm[15:8],
                     mdl_asm[23:16], b, fin);
          if (mdl_left > 0) mdl_left--;
          mdl_asm = '0;
          mdl_bip = '0;
          if (fin) mdl_phase = PH_IGNORE;
          else if (eof) raise_error(ERR_TRUNCATED);
        end
      end
      default: ;
    endcase
    if (eof) clear_stream();
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic check_record();
    ddsp_rec_t got;
    ddsp_rec_t want;
    got.record_kind     = out_if.record_kind;
    got.error_code      = out_if.error_code;
    got.image_width     = out_if.image_width;
    got.image_height    = out_if.image_height;
    got.source_was_bgra = out_if.source_was_bgra;
    got.red             = out_if.red;
    got.green           = out_if.green;
    got.blue            = out_if.blue;
    got.alpha           = out_if.alpha;
    got.final_pixel     = out_if.final_pixel;
    if (pending_records.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected record kind %0d err %0d", $realtime, got.record_kind,
                 got.error_code);
    end else begin
      want = pending_records.pop_front();
      if (got.record_kind !== want.record_kind || got.error_code !== want.error_code ||
          got.image_width !== want.image_width || got.image_height !== want.image_height ||
          got.source_was_bgra !== want.source_was_bgra || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue || got.alpha !== want.alpha ||
          got.final_pixel !== want.final_pixel) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: record mismatch (kind err width height bgra r g b a final)", $realtime);
          $display("  expected %0d %0d %h %h %b %h %h %h %h %b", want.record_kind,
                   want.error_code, want.image_width, want.image_height, want.source_was_bgra,
                   want.red, want.green, want.blue, want.alpha, want.final_pixel);
          $display("  actual   %0d %0d %h %h %b %h %h %h %h %b", got.record_kind,
                   got.error_code, got.image_width, got.image_height, got.source_was_bgra,
                   got.red, got.green, got.blue, got.alpha, got.final_pixel);
        end
      end
    end
  endtask

  // result side: check, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_record();
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (!no_idle) begin
      while ($urandom_range(99, 0) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.end_of_file <= eof;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    parse_byte_model(b, eof);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_pixels(input logic [3:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAX_PIXELS) mdl_max = value[40:0];
  endtask

  // ---------------------------------------------------------------- file builder
  function automatic dds_spec_t good_spec(src_fmt_t src, logic [31:0] w, logic [31:0] h);
    dds_spec_t   s;
    logic [63:0] count;
    s.magic    = DDS_MAGIC;
    s.hdr_size = HEADER_SIZE;
    s.width    = w;
    s.height   = h;
    s.flags    = $urandom;
    s.fourcc   = $urandom;
    s.bpp      = BPP_32;
    s.mask_r   = MASK_BYTE0;
    s.mask_g   = MASK_BYTE1;
    s.mask_b   = MASK_BYTE2;
    s.mask_a   = MASK_BYTE3;
    s.dxgi     = $urandom;
    s.fill     = -1;
    if (s.fourcc == FOURCC_DX10) s.fourcc = '0;
    case (src)
      SRC_RGB_MASKS: s.flags[FLAG_RGB_BIT] = 1'b1;
      SRC_BGR_MASKS: begin
        s.flags[FLAG_RGB_BIT] = 1'b1;
        s.mask_r = MASK_BYTE2;
        s.mask_b = MASK_BYTE0;
      end
      default: begin
        s.flags[FLAG_FOURCC_BIT] = 1'b1;
        s.fourcc = FOURCC_DX10;
        s.bpp    = $urandom_range(64, 0);
        s.mask_r = $urandom;
        s.dxgi   = (src == SRC_DX10_RGBA) ? DXGI_RGBA8 : DXGI_BGRA8;
      end
    endcase
    count = {32'b0, w} * {32'b0, h};
    s.payload_len = (count > PAYLOAD_CAP / 4) ? PAYLOAD_CAP : int'(count) * 4;
    return s;
  endfunction

  function automatic void push_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) file_q = {file_q, w[8*k +: 8]};
  endfunction

  function automatic void build_file(dds_spec_t s);
    logic [31:0] w;
    file_q.delete();
    push_word(s.magic);
    for (int ofs = 0; ofs < HEADER_SIZE; ofs += 4) begin
      case (ofs)
        0:   w = s.hdr_size;
        8:   w = s.height;
        12:  w = s.width;
        76:  w = s.flags;
        80:  w = s.fourcc;
        84:  w = s.bpp;
        88:  w = s.mask_r;
        92:  w = s.mask_g;
        96:  w = s.mask_b;
        100: w = s.mask_a;
        default: w = $urandom;
      endcase
      push_word(w);
    end
    if (s.flags[FLAG_FOURCC_BIT] && s.fourcc == FOURCC_DX10) begin
      push_word(s.dxgi);
      repeat (4) push_word($urandom);
    end
    repeat (s.payload_len)
      file_q = {file_q, ((s.fill < 0) ? 8'($urandom) : 8'(s.fill))};
  endfunction

  task automatic send_queue(input int pause_at);
    for (int i = 0; i < file_q.size(); i++) begin
      if (i == pause_at) wait_drain();
      send_byte(file_q[i], i == file_q.size() - 1);
    end
  endtask

  // cut > 0 ends the file after that many bytes
  task automatic send_file(input dds_spec_t s, input int cut, input int junk,
                           input int pause_at);
    build_file(s);
    repeat (junk) file_q = {file_q, 8'($urandom)};
    if (cut > 0) while (file_q.size() > cut) void'(file_q.pop_back());
    send_queue(pause_at);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_formats();
    dds_spec_t s;
    send_file(good_spec(SRC_RGB_MASKS, 2, 2), 0, 2, -1);
    send_file(good_spec(SRC_BGR_MASKS, 3, 1), 0, 0, -1);
    s = good_spec(SRC_DX10_RGBA, 1, 2);
    s.fill = 0;
    send_file(s, 0, 1, -1);
    s = good_spec(SRC_DX10_BGRA, 2, 1);
    s.fill = 255;
    send_file(s, 0, 3, -1);
    s = good_spec(SRC_DX10_RGBA, 1, 1);
    s.dxgi = DXGI_RGBA8 + 1;
    send_file(s, 0, 0, -1);
    s = good_spec(SRC_RGB_MASKS, 1, 1);
    s.bpp = 24;
    send_file(s, 0, 0, -1);
    s = good_spec(SRC_RGB_MASKS, 1, 1);
    s.flags = '0;
    send_file(s, 0, 0, -1);
    s = good_spec(SRC_BGR_MASKS, 1, 1);
    s.mask_a = MASK_BYTE1;
    send_file(s, 0, 0, -1);
    wait_drain();
  endtask

  task automatic test_header_faults();
    dds_spec_t s;
    s = good_spec(SRC_RGB_MASKS, 1, 1);
    s.magic = DDS_MAGIC ^ 32'h8000_0000;
    send_file(s, 0, 0, -1);
    send_file(good_spec(SRC_RGB_MASKS, 1, 1), 2, 0, -1);
    send_file(good_spec(SRC_RGB_MASKS, 1, 1), 4, 0, -1);
    send_file(good_spec(SRC_RGB_MASKS, 1, 1), 60, 0, -1);
    s = good_spec(SRC_RGB_MASKS, 1, 1);
    s.hdr_size = HEADER_SIZE - 1;
    send_file(s, 0, 0, -1);
    // end mark on the last header byte while an extension is due, then inside it
    send_file(good_spec(SRC_DX10_RGBA, 1, 1), 128, 0, -1);
    send_file(good_spec(SRC_DX10_BGRA, 1, 1), 135, 0, -1);
    send_file(good_spec(SRC_RGB_MASKS, 0, 5), 0, 0, -1);
    send_file(good_spec(SRC_DX10_RGBA, 5, 0), 0, 0, -1);
    wait_drain();
  endtask

  task automatic test_payload_faults();
    send_file(good_spec(SRC_RGB_MASKS, 1, 1), 128, 0, -1);
    send_file(good_spec(SRC_DX10_BGRA, 2, 2), 148, 0, -1);
    send_file(good_spec(SRC_RGB_MASKS, 2, 2), 134, 0, -1);
    send_file(good_spec(SRC_BGR_MASKS, 2, 2), 132, 0, -1);
    wait_drain();
  endtask

  task automatic test_limits();
    write_max_pixels(ADDR_MAX_PIXELS, 64'd1);
    send_file(good_spec(SRC_RGB_MASKS, 1, 1), 0, 0, -1);
    send_file(good_spec(SRC_RGB_MASKS, 2, 1), 0, 0, -1);
    wait_drain();
    write_max_pixels(ADDR_MAX_PIXELS, 64'd0);
    send_file(good_spec(SRC_BGR_MASKS, 1, 1), 0, 0, -1);
    wait_drain();
    // unmapped address leaves the limit alone
    write_max_pixels(ADDR_UNMAPPED, 64'd100);
    send_file(good_spec(SRC_DX10_RGBA, 1, 2), 0, 0, -1);
    wait_drain();
    // upper bits beyond the register width are dropped
    write_max_pixels(ADDR_MAX_PIXELS, '1);
    send_file(good_spec(SRC_DX10_RGBA, 32'h0010_0000, 32'h0010_0000), 0, 0, -1);
    send_file(good_spec(SRC_RGB_MASKS, 32'h0020_0000, 32'h0010_0000), 0, 0, -1);
    send_file(good_spec(SRC_BGR_MASKS, '1, '1), 0, 0, -1);
    wait_drain();
    write_max_pixels(ADDR_MAX_PIXELS, {23'b0, MAXPIX_RST});
    send_file(good_spec(SRC_RGB_MASKS, 32'h0000_8000, 32'h0000_8000), 0, 0, -1);
    send_file(good_spec(SRC_RGB_MASKS, 32'h0000_8001, 32'h0000_8000), 0, 0, -1);
    wait_drain();
  endtask

  // long receiver hold-off fills the record queue; later a mid-file pause drains it
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_file(good_spec(SRC_BGR_MASKS, 4, 4), 0, 0, 180);
    wait_drain();
  endtask

  task automatic random_file();
    dds_spec_t s;
    int        r;
    int        cut;
    r = $urandom_range(99, 0);
    if (r < 10) begin
      file_q.delete();
      repeat ($urandom_range(10, 1)) file_q = {file_q, 8'($urandom)};
      send_queue(-1);
    end else begin
      s = good_spec(src_fmt_t'($urandom_range(3, 0)), $urandom_range(4, 1),
                    $urandom_range(4, 1));
      r = $urandom_range(99, 0);
      if (r < 5) s.magic = s.magic ^ (32'h1 << $urandom_range(31, 0));
      else if (r < 10) s.hdr_size = $urandom_range(255, 0);
      else if (r < 20) begin
        case ($urandom_range(3, 0))
          0: s.flags = $urandom;
          1: s.dxgi = $urandom_range(100, 0);
          2: s.bpp = $urandom_range(64, 0);
          default: s.mask_g = s.mask_g ^ (32'h1 << $urandom_range(31, 0));
        endcase
      end else if (r < 25) begin
        if ($urandom_range(1, 0)) s.width = '0;
        else s.height = '0;
        s.payload_len = 0;
      end else if (r < 30) begin
        s.width       = $urandom;
        s.height      = $urandom_range(3, 0) == 0 ? 32'($urandom) : 32'($urandom_range(64, 1));
        s.payload_len = PAYLOAD_CAP;
      end
      build_file(s);
      cut = ($urandom_range(99, 0) < 15) ? $urandom_range(file_q.size(), 1) : 0;
      send_file(s, cut, $urandom_range(3, 0), -1);
    end
  endtask

  task automatic test_random();
    logic [40:0] limit;
    int          goal;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: limit = MAXPIX_RST;
        1: limit = $urandom_range(24, 1);
        2: limit = MAXPIX_ALL;
        default: limit = {9'($urandom), 32'($urandom)};
      endcase
      write_max_pixels(ADDR_MAX_PIXELS, {23'b0, limit});
      no_idle = (ph == 2);
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) random_file();
      wait_drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.end_of_file = 1'b0;
    out_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    hold_req          = 1'b0;
    hold_left         = 0;
    no_idle           = 1'b0;
    mismatches        = 0;
    bytes_sent        = 0;
    stall_cycles      = 0;
    clear_stream();
    mdl_max = MAXPIX_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_formats();
    test_header_faults();
    test_payload_faults();
    test_limits();
    test_backpressure();
    test_random();
    wait_drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ddsp_pkg.sv
rtl/core/ddsp_in_if.sv
rtl/core/ddsp_out_if.sv
rtl/core/ddsp_cfg.sv
rtl/core/ddsp_parse_core.sv
rtl/core/ddsp_out_fifo.sv
rtl/core/dds_rgba8_stream_parser.sv
tb/dds_rgba8_stream_parser_tb.sv
